>>> rtl/single_wire_power_link_unit_macros.svh
// Assertion macros shared by the single-wire power link checker.
`ifndef SINGLE_WIRE_POWER_LINK_UNIT_MACROS_SVH
`define SINGLE_WIRE_POWER_LINK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWPL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swpl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swpl assertion failed");

`endif

>>> rtl/swpl_pkg.sv
// Package with types, codes and constants of the single-wire power link.
package swpl_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int WORD_BITS         = 20;
   localparam int IDLE_BITS         = 8;
   localparam int NOW_BITS          = 32;
   localparam int CMD_BITS          = 4;
   localparam int PERIOD_BITS       = 10;
   localparam int PULSE_BITS        = 16;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 16;
   localparam int REQ_DATA_BITS     = 40;
   localparam int RSP_DATA_BITS     = 8;

   localparam logic [PERIOD_BITS-1:0] BIT_PERIOD_RESET  = 10'd50;
   localparam logic [PERIOD_BITS-1:0] LATE_LIMIT_RESET  = 10'd12;
   localparam logic [PERIOD_BITS-1:0] FIRST_DELAY_RESET = 10'd10;
   localparam logic [PULSE_BITS-1:0]  SHORT_MIN_RESET   = 16'd80;
   localparam logic [PULSE_BITS-1:0]  SHORT_MAX_RESET   = 16'd120;
   localparam logic [PULSE_BITS-1:0]  LONG_HOLD_RESET   = 16'd200;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BIT_PERIOD  = 3'd0,
      CSR_LATE_LIMIT  = 3'd1,
      CSR_FIRST_DELAY = 3'd2,
      CSR_SHORT_MIN   = 3'd3,
      CSR_SHORT_MAX   = 3'd4,
      CSR_LONG_HOLD   = 3'd5
   } csr_index_type;

   // Command codes: blank word, restart notice, ready notice, acknowledge,
   // three error reports and the shutdown request.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_NONE     = 4'd0,
      CMD_BLANK    = 4'd1,
      CMD_RESTART  = 4'd2,
      CMD_READY    = 4'd3,
      CMD_ACK      = 4'd4,
      CMD_ERROR1   = 4'd5,
      CMD_ERROR2   = 4'd6,
      CMD_ERROR3   = 4'd7,
      CMD_SHUTDOWN = 4'd8
   } cmd_type;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] bit_period;
      logic [PERIOD_BITS-1:0] late_limit;
      logic [PERIOD_BITS-1:0] first_delay;
      logic [PULSE_BITS-1:0]  short_min;
      logic [PULSE_BITS-1:0]  short_max;
      logic [PULSE_BITS-1:0]  long_hold;
   } cfg_type;

   typedef struct packed {
      logic pin_write;
      logic pin_level;
      logic restarted;
      logic sending;
   } tx_status_type;

   typedef struct packed {
      logic password_reset;
      logic power_off;
   } rx_status_type;

   // Fixed code word sent for each command; unknown codes give zero.
   function automatic logic [WORD_BITS-1:0] code_word(input logic [CMD_BITS-1:0] cmd);
      logic [WORD_BITS-1:0] word;
      unique case (cmd)
         CMD_BLANK:    word = 20'h001EA;
         CMD_RESTART:  word = 20'h003D6;
         CMD_READY:    word = 20'h003D2;
         CMD_ACK:      word = 20'h007A6;
         CMD_ERROR1:   word = 20'h003CA;
         CMD_ERROR2:   word = 20'h00792;
         CMD_ERROR3:   word = 20'h00F26;
         CMD_SHUTDOWN: word = 20'h00F36;
         default:      word = '0;
      endcase
      return word;
   endfunction

endpackage

>>> rtl/swpl_tx.sv
// Command transmitter: pending command, code word shifter and bit timing.
module swpl_tx #(
   parameter int TIME_BITS = swpl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [TIME_BITS-1:0]            now,
   input  logic [swpl_pkg::CMD_BITS-1:0]   cmd,
   input  swpl_pkg::cfg_type               cfg,
   output swpl_pkg::tx_status_type         status
);

   logic [swpl_pkg::WORD_BITS-1:0] packet_ff, packet_in;
   logic [swpl_pkg::WORD_BITS-1:0] shift_ff, shift_in;
   logic [swpl_pkg::WORD_BITS-1:0] prev_ff, prev_in;
   logic [TIME_BITS-1:0]           next_time_ff, next_time_in;
   logic [swpl_pkg::CMD_BITS-1:0]  pending_ff, pending_in;

   logic [swpl_pkg::CMD_BITS-1:0]  pend;
   logic [TIME_BITS-1:0]           period_t;
   logic [TIME_BITS-1:0]           late_time;
   logic                           busy;

   always_comb begin
      pend      = (cmd != swpl_pkg::CMD_NONE) ? cmd : pending_ff;
      period_t  = TIME_BITS'(cfg.bit_period);
      late_time = next_time_ff + TIME_BITS'(cfg.late_limit);
      busy      = (shift_ff | prev_ff) != '0;

      packet_in    = packet_ff;
      shift_in     = shift_ff;
      prev_in      = prev_ff;
      next_time_in = next_time_ff;
      pending_in   = pend;
      status.pin_write = 1'b0;
      status.pin_level = 1'b0;
      status.restarted = 1'b0;

      if (busy) begin
         if (now > next_time_ff) begin
            if (now > late_time) begin
               // Late poll: start over with idle bits ahead of the word.
               next_time_in     = now + period_t;
               shift_in         = packet_ff << swpl_pkg::IDLE_BITS;
               prev_in          = packet_ff << swpl_pkg::IDLE_BITS;
               status.restarted = 1'b1;
            end else begin
               next_time_in     = next_time_ff + period_t;
               status.pin_write = 1'b1;
               status.pin_level = shift_ff[0];
               prev_in          = shift_ff;
               shift_in         = shift_ff >> 1;
            end
         end
      end else if (pend != swpl_pkg::CMD_NONE) begin
         pending_in = swpl_pkg::CMD_NONE;
         if (pend inside {[swpl_pkg::CMD_BLANK:swpl_pkg::CMD_SHUTDOWN]}) begin
            packet_in    = swpl_pkg::code_word(pend);
            shift_in     = swpl_pkg::code_word(pend);
            prev_in      = swpl_pkg::code_word(pend);
            next_time_in = now + TIME_BITS'(cfg.first_delay) + period_t;
         end
      end

      status.sending = (shift_in | prev_in) != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_ff    <= '0;
         shift_ff     <= '0;
         prev_ff      <= '0;
         next_time_ff <= '0;
         pending_ff   <= swpl_pkg::CMD_NONE;
      end else if (step) begin
         packet_ff    <= packet_in;
         shift_ff     <= shift_in;
         prev_ff      <= prev_in;
         next_time_ff <= next_time_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

>>> rtl/swpl_rx.sv
// Decoder of the incoming wire: short pulse and long hold detection.
module swpl_rx #(
   parameter int TIME_BITS = swpl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [TIME_BITS-1:0]    now,
   input  logic                    rx_level,
   input  swpl_pkg::cfg_type       cfg,
   output swpl_pkg::rx_status_type status
);

   logic [TIME_BITS-1:0] rise_ff, rise_in;
   logic                 prior_ff;
   logic                 reset_flag_ff, reset_flag_in;
   logic                 off_flag_ff, off_flag_in;
   logic [TIME_BITS-1:0] delta;
   logic                 falling;

   always_comb begin
      rise_in = (rx_level && !prior_ff) ? now : rise_ff;
      delta   = now - rise_in;
      falling = !rx_level && prior_ff;

      status.password_reset = falling && !reset_flag_ff &&
                              (delta >= TIME_BITS'(cfg.short_min)) &&
                              (delta <= TIME_BITS'(cfg.short_max));
      status.power_off      = rx_level && !off_flag_ff &&
                              (delta > TIME_BITS'(cfg.long_hold));
      reset_flag_in = reset_flag_ff | status.password_reset;
      off_flag_in   = off_flag_ff | status.power_off;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff       <= '0;
         prior_ff      <= 1'b0;
         reset_flag_ff <= 1'b0;
         off_flag_ff   <= 1'b0;
      end else if (step) begin
         rise_ff       <= rise_in;
         prior_ff      <= rx_level;
         reset_flag_ff <= reset_flag_in;
         off_flag_ff   <= off_flag_in;
      end
   end

endmodule

>>> rtl/single_wire_power_link_unit.sv
// Top level of the single-wire power link: poll registers, config and result beat.
// An accepted poll beat is held in the input register, then its result beat in the result register.
// One poll beat per cycle while results drain; transmitter and decoder state update in one pass.
// The rate is set by the single combinational step between the input and result registers.
// Reset is synchronous and active high; it clears all link state and restores the
// register defaults (bit period 50, late limit 12, first delay 10, window 80..120, hold 200).
module single_wire_power_link_unit #(
   parameter int TIME_BITS = swpl_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata from bit 0: now_ms[31:0], rx_level, cmd[3:0], zero fill.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [swpl_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // rsp_tdata from bit 0: pin_write, pin_level, restarted, password_reset,
   // power_off, sending, poll_fast, zero fill.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [swpl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [swpl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swpl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers, written from the plain write port.
   swpl_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period  <= swpl_pkg::BIT_PERIOD_RESET;
         cfg_ff.late_limit  <= swpl_pkg::LATE_LIMIT_RESET;
         cfg_ff.first_delay <= swpl_pkg::FIRST_DELAY_RESET;
         cfg_ff.short_min   <= swpl_pkg::SHORT_MIN_RESET;
         cfg_ff.short_max   <= swpl_pkg::SHORT_MAX_RESET;
         cfg_ff.long_hold   <= swpl_pkg::LONG_HOLD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            swpl_pkg::CSR_BIT_PERIOD:  cfg_ff.bit_period  <= csr_wdata[swpl_pkg::PERIOD_BITS-1:0];
            swpl_pkg::CSR_LATE_LIMIT:  cfg_ff.late_limit  <= csr_wdata[swpl_pkg::PERIOD_BITS-1:0];
            swpl_pkg::CSR_FIRST_DELAY: cfg_ff.first_delay <= csr_wdata[swpl_pkg::PERIOD_BITS-1:0];
            swpl_pkg::CSR_SHORT_MIN:   cfg_ff.short_min   <= csr_wdata;
            swpl_pkg::CSR_SHORT_MAX:   cfg_ff.short_max   <= csr_wdata;
            swpl_pkg::CSR_LONG_HOLD:   cfg_ff.long_hold   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The input register holds one poll beat; the result register holds one result beat.
   // The poll moves on whenever the result register is empty or being drained. A result
   // beat that is not taken keeps the poll in the input register, and once both registers
   // are full the input stalls until the result beat is taken.
   logic                           in_valid_ff;
   logic [swpl_pkg::NOW_BITS-1:0]  now_ff;
   logic                           rx_ff;
   logic [swpl_pkg::CMD_BITS-1:0]  cmd_ff;
   logic                           rsp_valid_ff;
   logic [swpl_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                           advance;
   logic                           step;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         now_ff <= req_tdata[swpl_pkg::NOW_BITS-1:0];
         rx_ff  <= req_tdata[swpl_pkg::NOW_BITS];
         cmd_ff <= req_tdata[swpl_pkg::NOW_BITS+swpl_pkg::CMD_BITS:swpl_pkg::NOW_BITS+1];
      end
   end

   // Time runs modulo 2^TIME_BITS: the poll time is cut or zero-extended to that width.
   logic [TIME_BITS+swpl_pkg::NOW_BITS-1:0] now_wide;
   logic [TIME_BITS-1:0]                    now_t;

   assign now_wide = {{TIME_BITS{1'b0}}, now_ff};
   assign now_t    = now_wide[TIME_BITS-1:0];

   swpl_pkg::tx_status_type tx_status;
   swpl_pkg::rx_status_type rx_status;

   swpl_tx #(
      .TIME_BITS (TIME_BITS)
   ) u_tx (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .now    (now_t),
      .cmd    (cmd_ff),
      .cfg    (cfg_ff),
      .status (tx_status)
   );

   swpl_rx #(
      .TIME_BITS (TIME_BITS)
   ) u_rx (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .now      (now_t),
      .rx_level (rx_ff),
      .cfg      (cfg_ff),
      .status   (rx_status)
   );

   // Faster polling is asked for while a word is out or the incoming wire is high.
   always_comb begin
      rsp_data_in    = '0;
      rsp_data_in[0] = tx_status.pin_write;
      rsp_data_in[1] = tx_status.pin_level;
      rsp_data_in[2] = tx_status.restarted;
      rsp_data_in[3] = rx_status.password_reset;
      rsp_data_in[4] = rx_status.power_off;
      rsp_data_in[5] = tx_status.sending;
      rsp_data_in[6] = tx_status.sending | rx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/swpl_checker.sv
// Port-level checker for the single-wire power link and its bind statement.
`include "single_wire_power_link_unit_macros.svh"

module swpl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [swpl_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   // A driven high bit comes only with a driven bit.
   `SWPL_ASSERT_SAME(a_level_needs_write, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0])

   // A restart and a driven bit never share one poll.
   `SWPL_ASSERT_SAME(a_restart_or_write, clock, reset, rsp_tvalid && rsp_tdata[2], !rsp_tdata[0])

   // A restart or a driven one leaves the word still in flight, which asks for fast polling.
   `SWPL_ASSERT_SAME(a_busy_after_one, clock, reset,
                     rsp_tvalid && (rsp_tdata[2] || rsp_tdata[1]), rsp_tdata[5] && rsp_tdata[6])

   // A result beat that is not taken stays unchanged.
   `SWPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

endmodule

bind single_wire_power_link_unit swpl_checker u_swpl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
